FILE: rtl/core/ecbb_pkg.sv
// Shared types and constants for the edge-clipped box blur unit.
// Depends on nothing; every other source file but ecbb_ram imports it.
package ecbb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    localparam int CW    = 8;
    localparam int PW    = 3 * CW;
    localparam int CNTW  = 16;
    localparam int SW    = CNTW + CW;
    localparam int STEPW = $clog2(CW);

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [8:0] RST_IMG_W = 9'd256;
    localparam logic [8:0] RST_IMG_H = 9'd256;
    localparam logic [7:0] RST_WIN_W = 8'd3;
    localparam logic [7:0] RST_WIN_H = 8'd3;

    typedef enum logic [1:0] {
        REG_IMG_W = 2'd0,
        REG_IMG_H = 2'd1,
        REG_WIN_W = 2'd2,
        REG_WIN_H = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_LOAD,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic          func;
        logic [7:0]    x_coord;
        logic [7:0]    y_coord;
        logic [CW-1:0] red_in;
        logic [CW-1:0] green_in;
        logic [CW-1:0] blue_in;
    } t_req;

    typedef struct packed {
        logic [CW-1:0] red_out;
        logic [CW-1:0] green_out;
        logic [CW-1:0] blue_out;
    } t_rsp;

    typedef struct packed {
        logic [8:0] img_w;
        logic [8:0] img_h;
        logic [7:0] win_w;
        logic [7:0] win_h;
    } t_cfg;

    typedef logic [2:0][SW-1:0] t_sum3;
    typedef logic [2:0][CW-1:0] t_quot3;

endpackage

FILE: rtl/core/ecbb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ecbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ecbb_cfg.sv
// APB-style register file for image and window sizes.
// Depends on ecbb_pkg.
module ecbb_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ecbb_pkg::t_cfg o_cfg
);
    import ecbb_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_w <= RST_IMG_W;
            r_cfg.img_h <= RST_IMG_H;
            r_cfg.win_w <= RST_WIN_W;
            r_cfg.win_h <= RST_WIN_H;
        end else if (wr) begin
            unique case (idx)
                REG_IMG_W: r_cfg.img_w <= pwdata[8:0];
                REG_IMG_H: r_cfg.img_h <= pwdata[8:0];
                REG_WIN_W: r_cfg.win_w <= pwdata[7:0];
                REG_WIN_H: r_cfg.win_h <= pwdata[7:0];
                default:   r_cfg.win_h <= r_cfg.win_h;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_IMG_W: prdata = {23'd0, r_cfg.img_w};
            REG_IMG_H: prdata = {23'd0, r_cfg.img_h};
            REG_WIN_W: prdata = {24'd0, r_cfg.win_w};
            REG_WIN_H: prdata = {24'd0, r_cfg.win_h};
            default:   prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/ecbb_div.sv
// Restoring divider for three channel sums by one pixel count, one quotient bit a cycle.
// Depends on ecbb_pkg.
module ecbb_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  ecbb_pkg::t_sum3           i_sum,
    input  logic [ecbb_pkg::CNTW-1:0] i_count,
    output logic                      o_done,
    output ecbb_pkg::t_quot3          o_quot
);
    import ecbb_pkg::*;

    t_sum3            r_rem, n_rem;
    t_quot3           r_quot, n_quot;
    logic [CNTW-1:0]  r_den;
    logic [STEPW-1:0] r_step;
    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    shifted;

    assign shifted = SW'(r_den) << r_step;

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        for (int i = 0; i < 3; i++) begin
            if (r_rem[i] >= shifted) begin
                n_rem[i]          = r_rem[i] - shifted;
                n_quot[i][r_step] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_sum;
            r_den  <= i_count;
            r_quot <= '0;
            r_step <= STEPW'(CW - 1);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_step <= r_step - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/edge_clipped_box_blur_unit.sv
// Top level of the edge-clipped box blur unit: frame store, window sequencer, divider.
// Depends on ecbb_pkg, ecbb_ram, ecbb_cfg, ecbb_div.
//
// Requests enter on i_req, taken at a rising edge with start high and busy low.
// A store request writes one RGB pixel into the frame store in its accept cycle
// and leaves busy low, so stores may follow back to back. A query request inside
// the image sweeps the clipped window row by row, reading one pixel a cycle from
// the frame store's single read port, then divides the three channel sums by the
// pixel count, one quotient bit a cycle. The result appears on o_rsp with o_valid
// high for one cycle only, once the divider is done; busy is low again in that
// cycle, so the next request may be taken alongside it. A request outside the
// image is dropped without a result.
// The receiver must take every result as it is shown.
// Registers sit on the APB port: image_width, image_height, window_width and
// window_height at byte addresses 0, 4, 8 and 12; write them only while idle.
// Reset returns the sequencer to idle and the registers to 256, 256, 3, 3; the
// frame store keeps no reset and must be written before it is queried.
module edge_clipped_box_blur_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ecbb_pkg::t_req i_req,
    output logic           o_valid,
    output ecbb_pkg::t_rsp o_rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import ecbb_pkg::*;

    t_cfg            cfg;
    t_state          r_state, n_state;
    logic [8:0]      w_eff, h_eff;
    logic            in_image, accept, we, qry;
    logic [7:0]      rx, ry, sx, sy, ex, ey;
    logic [8:0]      x_end, y_end;
    logic [7:0]      r_col, r_row, r_sx, r_ex, r_ey;
    logic            last;
    logic            rd_en, div_start;
    logic            r_rd_vld;
    logic [PW-1:0]   rdata;
    t_sum3           r_sum;
    logic [CNTW-1:0] r_cnt;
    logic            div_done;
    t_quot3          quot;
    logic            r_out_vld;
    t_rsp            r_rsp;
    logic [AW-1:0]   waddr, raddr;

    ecbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign w_eff = (32'(cfg.img_w) > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : cfg.img_w;
    assign h_eff = (32'(cfg.img_h) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg.img_h;

    assign in_image = ({1'b0, i_req.x_coord} < w_eff) && ({1'b0, i_req.y_coord} < h_eff);
    assign accept   = start && !busy;
    assign we       = accept && in_image && (i_req.func == FUNC_STORE);
    assign qry      = accept && in_image && (i_req.func == FUNC_QUERY);

    assign rx    = {1'b0, cfg.win_w[7:1]};
    assign ry    = {1'b0, cfg.win_h[7:1]};
    assign sx    = (i_req.x_coord >= rx) ? i_req.x_coord - rx : 8'd0;
    assign sy    = (i_req.y_coord >= ry) ? i_req.y_coord - ry : 8'd0;
    assign x_end = {1'b0, i_req.x_coord} + {1'b0, rx};
    assign y_end = {1'b0, i_req.y_coord} + {1'b0, ry};
    assign ex    = (x_end < w_eff) ? x_end[7:0] : 8'(w_eff - 9'd1);
    assign ey    = (y_end < h_eff) ? y_end[7:0] : 8'(h_eff - 9'd1);

    assign last  = (r_col == r_ex) && (r_row == r_ey);
    assign waddr = AW'(32'(i_req.y_coord) * MAX_WIDTH + 32'(i_req.x_coord));
    assign raddr = AW'(32'(r_row) * MAX_WIDTH + 32'(r_col));

    ecbb_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({i_req.red_in, i_req.green_in, i_req.blue_in}),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ecbb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_sum),
        .i_count (r_cnt),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (qry) n_state = ST_READ;
            ST_READ:  if (last) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        rd_en     = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_READ:  rd_en = 1'b1;
            ST_DRAIN: busy = 1'b1;
            ST_LOAD:  div_start = 1'b1;
            ST_DIV:   busy = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= rd_en;
            r_out_vld <= div_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry) begin
            r_sx  <= sx;
            r_ex  <= ex;
            r_ey  <= ey;
            r_col <= sx;
            r_row <= sy;
        end else if (rd_en) begin
            if (r_col == r_ex) begin
                r_col <= r_sx;
                r_row <= r_row + 8'd1;
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
        if (qry) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_rd_vld) begin
            r_sum[2] <= r_sum[2] + SW'(rdata[3*CW-1:2*CW]);
            r_sum[1] <= r_sum[1] + SW'(rdata[2*CW-1:CW]);
            r_sum[0] <= r_sum[0] + SW'(rdata[CW-1:0]);
            r_cnt    <= r_cnt + 1'b1;
        end
        if (div_done) begin
            r_rsp.red_out   <= quot[2];
            r_rsp.green_out <= quot[1];
            r_rsp.blue_out  <= quot[0];
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

endmodule

FILE: rtl/core/ecbb_checker.sv
// Port-level checks for the edge-clipped box blur unit, bound to the top level.
// Depends on ecbb_pkg and edge_clipped_box_blur_unit.
module ecbb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input ecbb_pkg::t_req i_req,
    input logic           o_valid,
    input logic           pready
);
    import ecbb_pkg::*;

    a_store_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.func == FUNC_STORE) |=> !busy)
        else $error("store request left the unit busy");

    a_busy_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_result_ends_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result shown outside the end of a query");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind edge_clipped_box_blur_unit ecbb_checker u_ecbb_checker (.*);

FILE: tb/edge_clipped_box_blur_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for edge_clipped_box_blur_unit: directed and random pixel stores and
// blur queries against an in-bench box blur predictor, with APB register writes between phases.
// Depends on ecbb_pkg and the RTL of the unit.
module edge_clipped_box_blur_unit_tb;
    import ecbb_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 1150;

    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_ZERO
    } t_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_valid;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [PW-1:0] pixel_mem [DEPTH];
    bit            pixel_written [DEPTH];
    t_cfg          blur_cfg;
    t_rsp          expected_pixels [$];

    int fail_cnt = 0;
    int accepted_items = 0;
    int burst_left = 0;
    int cycle_cnt = 0;

    edge_clipped_box_blur_unit i_dut (
        .i_clk,
        .i_rst_n,
        .start,
        .busy,
        .i_req,
        .o_valid,
        .o_rsp,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("edge_clipped_box_blur_unit: mismatch");
            $finish;
        end
    end

    function automatic int eff_w();
        return (blur_cfg.img_w > MAX_WIDTH) ? MAX_WIDTH : int'(blur_cfg.img_w);
    endfunction

    function automatic int eff_h();
        return (blur_cfg.img_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(blur_cfg.img_h);
    endfunction

    function automatic void window_span(input int x, input int y,
                                        output int sx, output int sy,
                                        output int ex, output int ey);
        int rx, ry;
        rx = int'(blur_cfg.win_w) / 2;
        ry = int'(blur_cfg.win_h) / 2;
        sx = (x >= rx) ? x - rx : 0;
        sy = (y >= ry) ? y - ry : 0;
        ex = (x + rx < eff_w()) ? x + rx : eff_w() - 1;
        ey = (y + ry < eff_h()) ? y + ry : eff_h() - 1;
    endfunction

    function automatic void apply_request(t_req r);
        int x, y, sx, sy, ex, ey, count;
        int unsigned sum_r, sum_g, sum_b;
        logic [PW-1:0] p;
        t_rsp pix;
        x = int'(r.x_coord);
        y = int'(r.y_coord);
        if (x >= eff_w() || y >= eff_h()) return;
        if (r.func == FUNC_STORE) begin
            pixel_mem[y * MAX_WIDTH + x] = {r.red_in, r.green_in, r.blue_in};
            pixel_written[y * MAX_WIDTH + x] = 1'b1;
            return;
        end
        window_span(x, y, sx, sy, ex, ey);
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (int row = sy; row <= ey; row++) begin
            for (int col = sx; col <= ex; col++) begin
                p = pixel_mem[row * MAX_WIDTH + col];
                sum_r += p[23:16];
                sum_g += p[15:8];
                sum_b += p[7:0];
            end
        end
        count = (ex - sx + 1) * (ey - sy + 1);
        pix.red_out   = 8'(sum_r / count);
        pix.green_out = 8'(sum_g / count);
        pix.blue_out  = 8'(sum_b / count);
        expected_pixels.push_back(pix);
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: %h", o_rsp);
                fail_cnt++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_rsp.red_out !== want.red_out) begin
                    $error("red_out: expected %0d, got %0d", want.red_out, o_rsp.red_out);
                    fail_cnt++;
                end
                if (o_rsp.green_out !== want.green_out) begin
                    $error("green_out: expected %0d, got %0d", want.green_out, o_rsp.green_out);
                    fail_cnt++;
                end
                if (o_rsp.blue_out !== want.blue_out) begin
                    $error("blue_out: expected %0d, got %0d", want.blue_out, o_rsp.blue_out);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic t_req random_req();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(t_req)-1:0];
    endfunction

    function automatic t_req make_store(int x, int y, t_fill mode);
        t_req r;
        r = random_req();
        r.func    = FUNC_STORE;
        r.x_coord = 8'(x);
        r.y_coord = 8'(y);
        case (mode)
            FILL_MAX: begin
                {r.red_in, r.green_in, r.blue_in} = {PW{1'b1}};
            end
            FILL_ZERO: begin
                {r.red_in, r.green_in, r.blue_in} = {PW{1'b0}};
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        accepted_items++;
        apply_request(r);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_IMG_W: blur_cfg.img_w = val[8:0];
            REG_IMG_H: blur_cfg.img_h = val[8:0];
            REG_WIN_W: blur_cfg.win_w = val[7:0];
            REG_WIN_H: blur_cfg.win_h = val[7:0];
            default: begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_check(t_reg_idx idx, logic [31:0] want);
        logic [31:0] mask;
        logic [31:0] got;
        mask = (idx == REG_IMG_W || idx == REG_IMG_H) ? 32'h1FF : 32'hFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if ((got & mask) !== (want & mask)) begin
            $error("%s: expected %0d, got %0d", idx.name(), want & mask, got & mask);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [8:0] w, logic [8:0] h, logic [7:0] ww, logic [7:0] wh);
        wait_idle();
        reg_write(REG_IMG_W, ($urandom() & ~32'h1FF) | 32'(w));
        reg_write(REG_IMG_H, ($urandom() & ~32'h1FF) | 32'(h));
        reg_write(REG_WIN_W, ($urandom() & ~32'hFF) | 32'(ww));
        reg_write(REG_WIN_H, ($urandom() & ~32'hFF) | 32'(wh));
        reg_check(REG_IMG_W, 32'(w));
        reg_check(REG_IMG_H, 32'(h));
        reg_check(REG_WIN_W, 32'(ww));
        reg_check(REG_WIN_H, 32'(wh));
    endtask

    // fill every unwritten pixel of the clipped window, then query
    task automatic blur_query(int x, int y, t_fill mode);
        int sx, sy, ex, ey;
        t_req r;
        window_span(x, y, sx, sy, ex, ey);
        for (int row = sy; row <= ey; row++) begin
            for (int col = sx; col <= ex; col++) begin
                if (!pixel_written[row * MAX_WIDTH + col])
                    send_request(make_store(col, row, mode));
            end
        end
        r = random_req();
        r.func    = FUNC_QUERY;
        r.x_coord = 8'(x);
        r.y_coord = 8'(y);
        send_request(r);
    endtask

    task automatic query_outside();
        t_req r;
        r = random_req();
        r.func = FUNC_QUERY;
        if (eff_w() < MAX_WIDTH)
            r.x_coord = 8'($urandom_range(eff_w(), 255));
        else if (eff_h() < MAX_HEIGHT)
            r.y_coord = 8'($urandom_range(eff_h(), 255));
        else
            r.func = FUNC_STORE;
        send_request(r);
    endtask

    task automatic store_random();
        t_req r;
        r = make_store($urandom_range(0, 255), $urandom_range(0, 255), FILL_RANDOM);
        if (eff_w() > 0 && eff_h() > 0 && $urandom_range(0, 1) == 1) begin
            r.x_coord = 8'($urandom_range(0, eff_w() - 1));
            r.y_coord = 8'($urandom_range(0, eff_h() - 1));
        end
        send_request(r);
    endtask

    task automatic query_burst(int n);
        repeat (n) begin
            blur_query($urandom_range(0, eff_w() - 1), $urandom_range(0, eff_h() - 1),
                       FILL_RANDOM);
        end
    endtask

    task automatic test_reset_values();
        reg_check(REG_IMG_W, 32'(RST_IMG_W));
        reg_check(REG_IMG_H, 32'(RST_IMG_H));
        reg_check(REG_WIN_W, 32'(RST_WIN_W));
        reg_check(REG_WIN_H, 32'(RST_WIN_H));
    endtask

    task automatic test_directed();
        blur_query(0, 0, FILL_MAX);
        blur_query(255, 255, FILL_ZERO);
        blur_query(255, 0, FILL_MAX);
        blur_query(0, 255, FILL_RANDOM);
        blur_query(1, 1, FILL_RANDOM);
        send_request(make_store(0, 0, FILL_ZERO));
        blur_query(0, 0, FILL_RANDOM);
    endtask

    task automatic test_empty_image();
        set_config(9'd0, 9'd256, 8'd3, 8'd3);
        repeat (4) query_outside();
        repeat (4) store_random();
        set_config(9'd256, 9'd0, 8'd3, 8'd3);
        repeat (4) query_outside();
        repeat (4) store_random();
    endtask

    task automatic test_min_image();
        set_config(9'd1, 9'd1, 8'd255, 8'd255);
        blur_query(0, 0, FILL_RANDOM);
        repeat (3) query_outside();
        repeat (3) store_random();
        blur_query(0, 0, FILL_RANDOM);
    endtask

    task automatic test_oversize_image();
        set_config(9'd511, 9'd300, 8'd3, 8'd3);
        blur_query(255, 255, FILL_RANDOM);
        blur_query(255, 128, FILL_RANDOM);
        blur_query(128, 255, FILL_RANDOM);
        query_burst(6);
        set_config(9'd256, 9'd257, 8'd4, 8'd5);
        blur_query(255, 255, FILL_RANDOM);
        query_burst(6);
    endtask

    task automatic test_window_extremes();
        set_config(9'd12, 9'd9, 8'd255, 8'd255);
        query_burst(6);
        set_config(9'd12, 9'd9, 8'd0, 8'd0);
        query_burst(6);
        set_config(9'd12, 9'd9, 8'd255, 8'd1);
        query_burst(6);
        set_config(9'd12, 9'd9, 8'd2, 8'd254);
        query_burst(6);
    endtask

    task automatic test_random_mix();
        int first_cnt, ops, sel, mode;
        logic [8:0] w, h;
        logic [7:0] ww, wh;
        first_cnt = accepted_items;
        while (accepted_items - first_cnt < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
                w  = 9'($urandom_range(1, 16));
                h  = 9'($urandom_range(1, 16));
                ww = 8'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 6));
                wh = 8'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 6));
            end else if (mode <= 7) begin
                w  = 9'($urandom_range(17, 64));
                h  = 9'($urandom_range(17, 64));
                ww = 8'($urandom_range(0, 7));
                wh = 8'($urandom_range(0, 7));
            end else if (mode == 8) begin
                w  = 9'(($urandom_range(0, 1) == 1) ? $urandom_range(200, 511) : 256);
                h  = 9'(($urandom_range(0, 1) == 1) ? $urandom_range(200, 511) : 256);
                ww = 8'($urandom_range(0, 5));
                wh = 8'($urandom_range(0, 5));
            end else begin
                w  = 9'(($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 16));
                h  = (w == 9'd0) ? 9'($urandom_range(0, 20)) : 9'd0;
                ww = 8'($urandom_range(0, 255));
                wh = 8'($urandom_range(0, 255));
            end
            set_config(w, h, ww, wh);
            ops = (eff_w() == 0 || eff_h() == 0) ? 6 : $urandom_range(20, 80);
            repeat (ops) begin
                sel = $urandom_range(0, 19);
                if (eff_w() == 0 || eff_h() == 0 || sel < 2)
                    query_outside();
                else if (sel < 5)
                    store_random();
                else
                    query_burst(1);
                if ($urandom_range(0, 60) == 0)
                    wait_idle();
            end
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_req    <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        blur_cfg = '{img_w: RST_IMG_W, img_h: RST_IMG_H, win_w: RST_WIN_W, win_h: RST_WIN_H};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_empty_image();
        test_min_image();
        test_oversize_image();
        test_window_extremes();
        test_random_mix();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && expected_pixels.size() == 0) begin
            $display("edge_clipped_box_blur_unit: match");
        end else begin
            $display("edge_clipped_box_blur_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ecbb_pkg.sv
rtl/core/ecbb_ram.sv
rtl/core/ecbb_cfg.sv
rtl/core/ecbb_div.sv
rtl/core/edge_clipped_box_blur_unit.sv
rtl/core/ecbb_checker.sv
tb/edge_clipped_box_blur_unit_tb.sv
